// ===== hw/rtl/pps_pkg.sv =====
`default_nettype none

package pps_pkg;

  // Divider and search widths. The quotient of two 32-bit values fits in 32 bits.
  localparam int unsigned DIV_W   = 32;
  localparam int unsigned CNT_W   = $clog2(DIV_W);
  localparam int unsigned SCALE_W = 4;
  localparam int unsigned ERR_W   = DIV_W + 1;

  // Prescaler constants. The largest period, NATURAL_PERIOD << MAX_SCALE, fits in DIV_W bits.
  localparam logic [DIV_W-1:0]   NATURAL_PERIOD = DIV_W'(65536);
  localparam logic [SCALE_W-1:0] MAX_SCALE      = SCALE_W'(15);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic init;
    logic search_step;
    logic publish;
  } pps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic target_zero;
    logic div_last;
    logic stop;
  } pps_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pps_if.sv =====
`default_nettype none

// Request channel: one target frequency per transfer.
interface pps_req_if;
  logic                      valid;
  logic                      ready;
  logic [pps_pkg::DIV_W-1:0] target_freq;

  modport source (output valid, output target_freq, input ready);
  modport sink   (input valid, input target_freq, output ready);
endinterface

// Result channel: one prescaler exponent per transfer.
interface pps_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::SCALE_W-1:0] scale;

  modport source (output valid, output scale, input ready);
  modport sink   (input valid, input scale, output ready);
endinterface

// Configuration channel: writes the counter clock frequency.
interface pps_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [pps_pkg::DIV_W-1:0] input_clock_hz;

  modport source (output valid, output input_clock_hz, input ready);
  modport sink   (input valid, input input_clock_hz, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pps_datapath.sv =====
`default_nettype none

module pps_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [pps_pkg::DIV_W-1:0]   cfg_data,
  input  wire logic [pps_pkg::DIV_W-1:0]   target_freq,
  input  wire pps_pkg::pps_cmd_t           cmd,
  output pps_pkg::pps_status_t             status,
  output logic      [pps_pkg::SCALE_W-1:0] scale
);

  logic [pps_pkg::DIV_W-1:0]   clock_hz;
  logic [pps_pkg::DIV_W-1:0]   divisor;
  logic [pps_pkg::DIV_W-1:0]   quo;
  logic [pps_pkg::DIV_W-1:0]   rem;
  logic [pps_pkg::CNT_W-1:0]   cnt;
  logic [pps_pkg::DIV_W-1:0]   period;
  logic [pps_pkg::ERR_W-1:0]   err;
  logic [pps_pkg::SCALE_W-1:0] sc;

  logic [pps_pkg::DIV_W:0]     rem_sh;
  logic [pps_pkg::DIV_W:0]     rem_sub;
  logic                        fits;
  logic [pps_pkg::ERR_W-1:0]   want_ext;
  logic [pps_pkg::ERR_W-1:0]   nat_ext;
  logic [pps_pkg::ERR_W-1:0]   next;
  logic [pps_pkg::ERR_W-1:0]   next_err;
  logic [pps_pkg::ERR_W:0]     err2;
  logic [pps_pkg::ERR_W-1:0]   init_err;

  // One restoring divide step: shift in the next dividend bit, subtract if it fits.
  // The shifted remainder is below twice the divisor, so a borrow shows in the top bit.
  assign rem_sh  = {rem, quo[pps_pkg::DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = !rem_sub[pps_pkg::DIV_W];

  // After the divide, quo holds the target period.
  assign want_ext = {1'b0, quo};
  assign nat_ext  = {1'b0, pps_pkg::NATURAL_PERIOD};
  assign init_err = (want_ext > nat_ext) ? want_ext - nat_ext : nat_ext - want_ext;
  assign next     = {period, 1'b0};
  assign next_err = (want_ext > next) ? want_ext - next : next - want_ext;
  assign err2     = {err, 1'b0};

  assign status.target_zero = (target_freq == '0);
  assign status.div_last    = (cnt == pps_pkg::CNT_W'(pps_pkg::DIV_W - 1));
  assign status.stop        = (sc == pps_pkg::MAX_SCALE) ||
                              ((want_ext < next) && ({1'b0, next_err} >= err2));

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= '0;
    end else if (cfg_write) begin
      clock_hz <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor <= target_freq;
      quo     <= clock_hz;
      rem     <= '0;
      cnt     <= '0;
      sc      <= status.target_zero ? pps_pkg::MAX_SCALE : '0;
    end
    if (cmd.div_step) begin
      if (fits) begin
        rem <= rem_sub[pps_pkg::DIV_W-1:0];
        quo <= {quo[pps_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[pps_pkg::DIV_W-1:0];
        quo <= {quo[pps_pkg::DIV_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
    if (cmd.init) begin
      period <= pps_pkg::NATURAL_PERIOD;
      err    <= init_err;
    end
    if (cmd.search_step && !status.stop) begin
      period <= next[pps_pkg::DIV_W-1:0];
      err    <= next_err;
      sc     <= sc + 1'b1;
    end
    if (cmd.publish) begin
      scale <= sc;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pps_ctrl.sv =====
`default_nettype none

module pps_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  input  wire pps_pkg::pps_status_t status,
  output pps_pkg::pps_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INIT,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.load        = (state == ST_IDLE) && req_valid;
    cmd.div_step    = (state == ST_DIV);
    cmd.init        = (state == ST_INIT);
    cmd.search_step = (state == ST_SEARCH);
    cmd.publish     = (state == ST_FINISH) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // A new result refills the output register in the cycle it empties.
      if ((state == ST_FINISH) && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= status.target_zero ? ST_FINISH : ST_DIV;
          end
        end
        ST_DIV: begin
          if (status.div_last) begin
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (status.stop) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pwm_prescale_chooser.sv =====
`default_nettype none

// A zero target skips straight to the result hand-off; any other runs a divide step per
// quotient bit, a setup step, search steps up to the stop decision and the result hand-off.
// Only one request is in flight at a time, and the serial divider sets the pace.
// A finished result waits in an output register, so the next request is taken meanwhile.
// Reset (rst, synchronous, active high) idles the controller, drops the result and
// clears the clock frequency register to zero.
module pwm_prescale_chooser (
  input  wire logic clk,
  input  wire logic rst,
  pps_cfg_if.sink   cfg,
  pps_req_if.sink   req,
  pps_rsp_if.source rsp
);

  pps_pkg::pps_cmd_t    cmd;
  pps_pkg::pps_status_t status;

  // The clock frequency register takes a write on every cycle; software must write it
  // only while no request is in progress, which the block itself does not enforce.
  assign cfg.ready = 1'b1;

  // The controller sequences each request: load, serial divide of the clock frequency by
  // the target, doubling search, result hand-off; a zero target skips to the hand-off.
  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the divider, the period and error registers of the search, and
  // the result register that drives the scale on the response channel.
  pps_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg.valid),
    .cfg_data    (cfg.input_clock_hz),
    .target_freq (req.target_freq),
    .cmd         (cmd),
    .status      (status),
    .scale       (rsp.scale)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pps_pkg::*;

  // Clock, reset and the three channels of the block.
  logic clk;
  logic rst;

  pps_cfg_if cfg_ch ();
  pps_req_if req_ch ();
  pps_rsp_if rsp_ch ();

  pwm_prescale_chooser u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 10 ns period, high and low halves.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // One row of the directed table. When has_scale is set, the expected exponent is
  // typed in by hand; otherwise the row is checked against the predictor.
  typedef struct packed {
    logic [DIV_W-1:0]   clock_hz;
    logic [DIV_W-1:0]   target_freq;
    logic               has_scale;
    logic [SCALE_W-1:0] scale;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // Clock still at its reset value of zero: a zero target gives the largest scale,
    // any other target has a target period of zero and stops the search at once.
    '{32'd0,          32'd0,          1'b1, 4'd15},
    '{32'd0,          32'd1,          1'b1, 4'd0},
    '{32'd0,          32'hFFFF_FFFF,  1'b1, 4'd0},
    // Fastest clock. Target 1 asks for a period above every reachable one, so the
    // search runs to the top; the fastest target asks for a period of one count.
    '{32'hFFFF_FFFF,  32'd0,          1'b1, 4'd15},
    '{32'hFFFF_FFFF,  32'd1,          1'b1, 4'd15},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 4'd0},
    '{32'hFFFF_FFFF,  32'd2,          1'b0, 4'd0},
    '{32'hFFFF_FFFF,  32'd3,          1'b0, 4'd0},
    '{32'hFFFF_FFFF,  32'd100,        1'b0, 4'd0},
    '{32'hFFFF_FFFF,  32'd1000,       1'b0, 4'd0},
    '{32'hFFFF_FFFF,  32'd40000,      1'b0, 4'd0},
    '{32'hFFFF_FFFF,  32'd65535,      1'b0, 4'd0},
    '{32'hFFFF_FFFF,  32'd65537,      1'b0, 4'd0},
    '{32'hFFFF_FFFF,  32'h5555_5555,  1'b0, 4'd0},
    '{32'hFFFF_FFFF,  32'hAAAA_AAAA,  1'b0, 4'd0},
    // A typical 100 MHz counter clock, around the natural-period boundary.
    '{32'd100_000_000, 32'd1,         1'b0, 4'd0},
    '{32'd100_000_000, 32'd50,        1'b0, 4'd0},
    '{32'd100_000_000, 32'd1000,      1'b0, 4'd0},
    '{32'd100_000_000, 32'd1525,      1'b0, 4'd0},
    '{32'd100_000_000, 32'd1526,      1'b0, 4'd0},
    '{32'd100_000_000, 32'd20000,     1'b0, 4'd0},
    // Slowest nonzero clock.
    '{32'd1,          32'd1,          1'b0, 4'd0},
    '{32'd1,          32'd2,          1'b0, 4'd0},
    // Clock exactly at the largest reachable period.
    '{32'h8000_0000,  32'd1,          1'b0, 4'd0}
  };

  localparam int RAND_PHASES    = 9;
  localparam int ITEMS_PER_PHASE = 84;

  // The receiver holds off once for a long stretch after this many results.
  localparam int HOLD_AT  = 300;
  localparam int HOLD_LEN = 500;

  // Expected exponents, oldest first, and the shadow of the clock register.
  logic [SCALE_W-1:0] exp_scale_q [$];
  logic [DIV_W-1:0]   clock_hz_now;

  int errors;
  int results_seen;

  // Result-side pacing state.
  int  stall_left;
  int  calm_left;
  int  hold_left;
  bit  hold_done;
  logic [SCALE_W-1:0] want_scale;

  // Sender-side pacing state.
  int send_calm;

  // Works out the exponent the block should choose for one target at one clock rate.
  // All periods and errors are held at 64 bits so nothing wraps.
  function automatic logic [SCALE_W-1:0] predict_scale(logic [DIV_W-1:0] clock_hz,
                                                       logic [DIV_W-1:0] target_freq);
    logic [63:0]        want;
    logic [63:0]        period;
    logic [63:0]        err;
    logic [63:0]        nxt;
    logic [63:0]        nxt_err;
    logic [SCALE_W-1:0] sc;
    bit                 done;
    if (target_freq == '0) begin
      return MAX_SCALE;
    end
    want   = 64'(clock_hz) / 64'(target_freq);
    period = 64'(NATURAL_PERIOD);
    err    = (want > period) ? want - period : period - want;
    sc     = '0;
    done   = 1'b0;
    while (!done && sc < MAX_SCALE) begin
      nxt     = period << 1;
      nxt_err = (want > nxt) ? want - nxt : nxt - want;
      if (want < nxt && nxt_err >= (err << 1)) begin
        done = 1'b1;
      end else begin
        period = nxt;
        err    = nxt_err;
        sc     = sc + 1'b1;
      end
    end
    return sc;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at %0t: %s (got %0d, expected %0d)", $realtime, what, got, want);
  endtask

  // Picks a target. Most of them are aimed at a target period near one of the
  // power-of-two periods, so the search ends at every scale and on both sides of
  // each stop decision; the rest are zero, small or fully random.
  function automatic logic [DIV_W-1:0] pick_target(logic [DIV_W-1:0] clock_hz);
    int unsigned r;
    int unsigned k;
    logic [63:0] base;
    logic [63:0] spread;
    logic [63:0] goal;
    logic [63:0] t;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      return '0;
    end else if (r < 30) begin
      return $urandom;
    end else if (r < 48) begin
      return DIV_W'($urandom_range(1, 65535));
    end
    k      = $urandom_range(0, 16);
    base   = 64'(NATURAL_PERIOD) << k;
    spread = base >> $urandom_range(1, 12);
    goal   = base - spread + ({32'h0, $urandom} % (2 * spread + 1));
    if (goal == 0) begin
      goal = 1;
    end
    t = 64'(clock_hz) / goal;
    // A one-count nudge moves the target period across rounding boundaries.
    case ($urandom_range(0, 2))
      0: t = t + 1;
      1: t = (t > 1) ? t - 1 : t;
      default: ;
    endcase
    if (t == 0) begin
      t = 1;
    end
    if (t > 64'hFFFF_FFFF) begin
      t = 64'hFFFF_FFFF;
    end
    return t[DIV_W-1:0];
  endfunction

  // Offers one target until it transfers, then records what should come back.
  // valid stays high when no gap follows, so back-to-back requests never lower it.
  task automatic send_target(logic [DIV_W-1:0] target_freq, bit typed,
                             logic [SCALE_W-1:0] typed_scale);
    int unsigned r;
    int          gap;
    req_ch.valid       <= 1'b1;
    req_ch.target_freq <= target_freq;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    exp_scale_q.push_back(typed ? typed_scale : predict_scale(clock_hz_now, target_freq));
    // Gap before the next request: mostly none or short, a few long, and now and
    // then a calm stretch with no gaps at all.
    gap = 0;
    if (send_calm > 0) begin
      send_calm--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_calm = $urandom_range(20, 60);
      end else if (r < 4) begin
        gap = $urandom_range(40, 120);
      end else if (r < 12) begin
        gap = $urandom_range(5, 30);
      end else if (r < 42) begin
        gap = $urandom_range(1, 4);
      end
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every expected result has come back, which leaves
  // the block idle since each request gives exactly one result.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (exp_scale_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the clock frequency register; only called while the block is idle.
  task automatic write_clock(logic [DIV_W-1:0] clock_hz);
    drain_results();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.input_clock_hz <= clock_hz;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    clock_hz_now = clock_hz;
  endtask

  // Result side: checks every transfer against the oldest expectation, then decides
  // ready for the next cycle. Both happen in one process so the counts stay in step.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (exp_scale_q.size() == 0) begin
        report_mismatch("result with nothing expected", int'(rsp_ch.scale), -1);
      end else begin
        want_scale = exp_scale_q.pop_front();
        if (rsp_ch.scale !== want_scale) begin
          report_mismatch("scale", int'(rsp_ch.scale), int'(want_scale));
        end
      end
      results_seen++;
    end

    if (hold_left > 0) begin
      // The long hold-off: the sender keeps offering, so the block fills its result
      // register and then stalls its request channel.
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      rsp_ch.ready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      rsp_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:0]:   calm_left  = $urandom_range(100, 200);
        [1:3]:   stall_left = $urandom_range(20, 60);
        [4:28]:  stall_left = $urandom_range(1, 3);
        default: ;
      endcase
      rsp_ch.ready <= (stall_left == 0);
    end
  end

  // Main stimulus: reset, the directed table, then random phases at different clock
  // rates with the register rewritten between phases.
  initial begin
    logic [DIV_W-1:0] phase_clock;
    errors       = 0;
    results_seen = 0;
    stall_left   = 0;
    calm_left    = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    send_calm    = 0;
    clock_hz_now = '0;

    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.target_freq    <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.input_clock_hz <= '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The clock register is rewritten only where a row changes it.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].clock_hz != clock_hz_now) begin
        write_clock(dir_rows[i].clock_hz);
      end
      send_target(dir_rows[i].target_freq, dir_rows[i].has_scale, dir_rows[i].scale);
    end

    // Random part. Each phase writes the register, including both extremes.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0, 7:    phase_clock = 32'hFFFF_FFFF;
        1:       phase_clock = 32'd0;
        3:       phase_clock = DIV_W'($urandom_range(1_000_000, 200_000_000));
        5:       phase_clock = 32'd1;
        default: phase_clock = $urandom;
      endcase
      write_clock(phase_clock);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Once, mid-run, the sender pauses until the block has answered everything.
        if (p == 4 && n == ITEMS_PER_PHASE / 2) begin
          drain_results();
        end
        send_target(pick_target(clock_hz_now), 1'b0, '0);
      end
    end

    // Wait for the last results, then a little longer for any stray one.
    drain_results();
    repeat (60) @(posedge clk);
    if (exp_scale_q.size() != 0) begin
      report_mismatch("results never arrived", 0, exp_scale_q.size());
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(64'd20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
